// ===== rtl/nmx_pkg.sv =====
// Shared types, constants and helper functions of the nixie multiplex/effect driver.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps
`default_nettype none
package nmx_pkg;

   localparam int TUBES          = 6;
   localparam int SLOT_MS_DEF    = 3;
   localparam int FADE_STEPS_DEF = 100;

   localparam int DIGIT_W    = 4;
   localparam int SLOT_W     = 3;
   localparam int ELAPSED_W  = 13;
   localparam int ON_W       = 12;
   localparam int CATH_W     = 16;
   localparam int LIGHT_W    = 12;
   localparam int BRIGHT_W   = 16;
   localparam int LEVEL_W    = 8;
   localparam int DIV_NUM_W  = 28;
   localparam int DIV_DEN_W  = 12;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 13'd8191;
   localparam logic [ELAPSED_W-1:0] T_SHUF       = 13'd1000;
   localparam logic [ELAPSED_W-1:0] T_SEQ        = 13'd600;
   localparam logic [ELAPSED_W-1:0] T_HOURLY     = 13'd3000;
   localparam logic [ELAPSED_W-1:0] T_DEMO       = 13'd5000;
   localparam logic [ELAPSED_W-1:0] T_LOCK_RES   = 13'd3000;
   localparam logic [ELAPSED_W-1:0] STEP_SEQ     = 13'd100;
   localparam logic [ELAPSED_W-1:0] STEP_LOCK    = 13'd500;

   localparam logic [CATH_W-1:0]   NO_CATH      = 16'hFFFF;
   localparam logic [15:0]         LFSR_SEED    = 16'hACE1;
   localparam logic [15:0]         LFSR_MASK    = 16'hB400;
   localparam logic [BRIGHT_W-1:0] BRIGHT_LO_FX = 16'h1400;   // 20.0
   localparam logic [BRIGHT_W-1:0] BRIGHT_HI_FX = 16'hFF00;   // 255.0
   localparam logic [15:0]         TGT_SCALE    = 16'd60160;  // 235 * 256
   localparam logic [6:0]          ROUND_HALF   = 7'd50;
   localparam logic [11:0]         LEVEL_SCALE  = 12'd2700;
   localparam logic [ON_W-1:0]     ON_BASE      = 12'd100;
   localparam logic [DIV_DEN_W-1:0] DEN_HUNDRED = 12'd100;
   localparam logic [DIV_DEN_W-1:0] DEN_LEVEL   = 12'd255;

   // display_mode codes; the unused code behaves as a plain switch
   localparam logic [1:0] DISP_SWITCH = 2'd0;
   localparam logic [1:0] DISP_FADE   = 2'd1;
   localparam logic [1:0] DISP_XFADE  = 2'd2;
   localparam logic [1:0] DISP_SPARE  = 2'd3;

   localparam logic [2:0] CSR_DISPLAY_MODE = 3'd0;
   localparam logic [2:0] CSR_BRIGHT_AUTO  = 3'd1;
   localparam logic [2:0] CSR_BRIGHT_LEVEL = 3'd2;
   localparam logic [2:0] CSR_LIGHT_MIN    = 3'd3;
   localparam logic [2:0] CSR_LIGHT_MAX    = 3'd4;

   typedef enum logic [3:0] {
      MODE_ON       = 4'd0,
      MODE_OFF_SHUF = 4'd1,
      MODE_OFF_SEQ  = 4'd2,
      MODE_OFF      = 4'd3,
      MODE_ON_SEQ   = 4'd4,
      MODE_ON_SHUF  = 4'd5,
      MODE_ON_RES   = 4'd6,
      MODE_HR_SHUF  = 4'd7,
      MODE_HR_RES   = 4'd8,
      MODE_DM_SHUF  = 4'd9,
      MODE_DM_RES   = 4'd10
   } mode_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_REQ, OP_LFSR, OP_TIMER, OP_FADE,
      OP_TGT, OP_SMO, OP_MAX, OP_OLD, OP_NEW, OP_EMIT
   } dp_op_type;

   typedef enum logic [1:0] {DIV_TGT, DIV_HUNDRED, DIV_LEVEL, DIV_FADE} div_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_REQ, ST_LFSR, ST_TIMER, ST_FADE,
      ST_TGT_GO, ST_TGT_WAIT, ST_TGT_USE,
      ST_SMO_GO, ST_SMO_WAIT, ST_SMO_USE,
      ST_MAX_GO, ST_MAX_WAIT, ST_MAX_USE,
      ST_OLD_GO, ST_OLD_WAIT, ST_OLD_USE,
      ST_NEW_GO, ST_NEW_WAIT, ST_NEW_USE,
      ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      dp_op_type         op;
      logic              div_start;
      div_sel_type       div_sel;
      logic [SLOT_W-1:0] tube;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
   } dp_status_type;

   typedef struct packed {
      logic [1:0]         display_mode;
      logic               brightness_auto;
      logic [LEVEL_W-1:0] brightness_level;
      logic [LIGHT_W-1:0] light_min;
      logic [LIGHT_W-1:0] light_max;
   } cfg_type;

   // active-low cathode pattern; zero sits on line 9
   function automatic logic [CATH_W-1:0] cath(input logic [DIGIT_W-1:0] v);
      logic [CATH_W-1:0] onehot;
      onehot = '0;
      if (v == 4'd0) onehot[9] = 1'b1;
      else if (v <= 4'd9) onehot[v - 4'd1] = 1'b1;
      return ~onehot;
   endfunction

   // x mod 10: 16^k = 6 (mod 10), then reciprocal of 10 on the small sum
   function automatic logic [DIGIT_W-1:0] mod10(input logic [15:0] x);
      logic [8:0]  s;
      logic [16:0] p;
      logic [5:0]  q;
      logic [8:0]  r;
      s = 9'(x[3:0]) + 9'd6 * (9'(x[7:4]) + 9'(x[11:8]) + 9'(x[15:12]));
      p = 17'(s) * 17'd205;
      q = p[16:11];
      r = s - 9'd10 * 9'(q);
      return r[DIGIT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/nixie_multiplex_effect_driver_unit.sv =====
// Top level of the nixie multiplex/effect driver: CSR block, sequencer and datapath.
// Depends on nmx_pkg, nmx_ctrl, nmx_dp (and nmx_div below it).
// Processing: each request runs its setup steps, then five passes through the shared
//   divider, each with setup and writeback, then waits to emit while the output is stalled.
// Requests are taken one at a time; a new request is taken while the previous
//   result still waits in the output register.
// Reset: synchronous, active high; display off, timers clear, LFSR seeded, CSRs at defaults.
`timescale 1ns / 1ps
`default_nettype none
module nixie_multiplex_effect_driver_unit #(
   parameter int SLOT_MS    = nmx_pkg::SLOT_MS_DEF,
   parameter int FADE_STEPS = nmx_pkg::FADE_STEPS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_data_valid,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]       req_digit_a,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]       req_digit_b,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]       req_digit_c,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]       req_digit_d,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]       req_digit_e,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]       req_digit_f,
   input  wire logic                              req_power_off_request,
   input  wire logic                              req_hourly_trigger,
   input  wire logic                              req_demo_trigger,
   input  wire logic [nmx_pkg::LIGHT_W-1:0]       req_ambient_light,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [nmx_pkg::SLOT_W-1:0]             rsp_slot_digit,
   output logic [nmx_pkg::CATH_W-1:0]             rsp_old_cathodes,
   output logic [nmx_pkg::ON_W-1:0]               rsp_old_on_us,
   output logic [nmx_pkg::CATH_W-1:0]             rsp_new_cathodes,
   output logic [nmx_pkg::ON_W-1:0]               rsp_new_on_us,
   output logic                                   rsp_high_voltage_on,
   output logic [3:0]                             rsp_mode_now,
   // CSR port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [nmx_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [nmx_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [nmx_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);
   import nmx_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic [2:0]    csr_idx;
   logic          csr_wr;

   // word-aligned registers; low address bits ignored
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_DISPLAY_MODE: cfg_in.display_mode     = pwdata[1:0];
            CSR_BRIGHT_AUTO:  cfg_in.brightness_auto  = pwdata[0];
            CSR_BRIGHT_LEVEL: cfg_in.brightness_level = pwdata[LEVEL_W-1:0];
            CSR_LIGHT_MIN:    cfg_in.light_min        = pwdata[LIGHT_W-1:0];
            CSR_LIGHT_MAX:    cfg_in.light_max        = pwdata[LIGHT_W-1:0];
            default:          cfg_in = cfg_ff;   // writes past the map are dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_DISPLAY_MODE: prdata = CSR_DATA_W'(cfg_ff.display_mode);
         CSR_BRIGHT_AUTO:  prdata = CSR_DATA_W'(cfg_ff.brightness_auto);
         CSR_BRIGHT_LEVEL: prdata = CSR_DATA_W'(cfg_ff.brightness_level);
         CSR_LIGHT_MIN:    prdata = CSR_DATA_W'(cfg_ff.light_min);
         CSR_LIGHT_MAX:    prdata = CSR_DATA_W'(cfg_ff.light_max);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_mode     <= DISP_SWITCH;
         cfg_ff.brightness_auto  <= 1'b0;
         cfg_ff.brightness_level <= 8'd255;
         cfg_ff.light_min        <= 12'd100;
         cfg_ff.light_max        <= 12'd3000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: one step of the request per state, divider waits in between
   nmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath owns all effect state and the output register
   nmx_dp #(.SLOT_MS(SLOT_MS), .FADE_STEPS(FADE_STEPS)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .cfg                   (cfg_ff),
      .req_data_valid        (req_data_valid),
      .req_digit_a           (req_digit_a),
      .req_digit_b           (req_digit_b),
      .req_digit_c           (req_digit_c),
      .req_digit_d           (req_digit_d),
      .req_digit_e           (req_digit_e),
      .req_digit_f           (req_digit_f),
      .req_power_off_request (req_power_off_request),
      .req_hourly_trigger    (req_hourly_trigger),
      .req_demo_trigger      (req_demo_trigger),
      .req_ambient_light     (req_ambient_light),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_slot_digit        (rsp_slot_digit),
      .rsp_old_cathodes      (rsp_old_cathodes),
      .rsp_old_on_us         (rsp_old_on_us),
      .rsp_new_cathodes      (rsp_new_cathodes),
      .rsp_new_on_us         (rsp_new_on_us),
      .rsp_high_voltage_on   (rsp_high_voltage_on),
      .rsp_mode_now          (rsp_mode_now)
   );
endmodule
`default_nettype wire

// ===== rtl/nmx_div.sv =====
// Restoring divider, two quotient bits per cycle, shared by all datapath divisions.
// Depends on nmx_pkg (widths).
`timescale 1ns / 1ps
`default_nettype none
module nmx_div #(
   parameter int NUM_W = nmx_pkg::DIV_NUM_W,
   parameter int DEN_W = nmx_pkg::DIV_DEN_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quo
);
   localparam int STEPS = NUM_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   r1, r2, r1s, r2s;
   logic             ge1, ge2;

   always_comb begin
      r1  = {rem_ff, quo_ff[NUM_W-1]};
      ge1 = r1 >= {1'b0, den_ff};
      r1s = ge1 ? r1 - {1'b0, den_ff} : r1;
      r2  = {r1s[DEN_W-1:0], quo_ff[NUM_W-2]};
      ge2 = r2 >= {1'b0, den_ff};
      r2s = ge2 ? r2 - {1'b0, den_ff} : r2;

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = r2s[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-3:0], ge1, ge2};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/nmx_ctrl.sv =====
// Sequencer of the driver: walks one request through the datapath steps.
// Depends on nmx_pkg (state, command and status types).
`timescale 1ns / 1ps
`default_nettype none
module nmx_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output nmx_pkg::dp_cmd_type         cmd,
   input  wire nmx_pkg::dp_status_type status
);
   import nmx_pkg::*;

   ctl_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] tube_ff, tube_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tube_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tube_ff  <= tube_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      tube_in       = tube_ff;
      cmd.op        = OP_NONE;
      cmd.div_start = 1'b0;
      cmd.div_sel   = DIV_TGT;
      cmd.tube      = tube_ff;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_REQ;
            end
         end
         ST_REQ: begin
            cmd.op   = OP_REQ;
            tube_in  = '0;
            state_in = ST_LFSR;
         end
         ST_LFSR: begin
            cmd.op  = OP_LFSR;
            tube_in = tube_ff + 1'b1;
            if (tube_ff == SLOT_W'(TUBES - 1)) state_in = ST_TIMER;
         end
         ST_TIMER: begin
            cmd.op   = OP_TIMER;
            state_in = ST_FADE;
         end
         ST_FADE: begin
            cmd.op   = OP_FADE;
            state_in = ST_TGT_GO;
         end
         ST_TGT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TGT;
            state_in      = ST_TGT_WAIT;
         end
         ST_TGT_WAIT: if (status.div_done) state_in = ST_TGT_USE;
         ST_TGT_USE: begin
            cmd.op   = OP_TGT;
            state_in = ST_SMO_GO;
         end
         ST_SMO_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_HUNDRED;
            state_in      = ST_SMO_WAIT;
         end
         ST_SMO_WAIT: if (status.div_done) state_in = ST_SMO_USE;
         ST_SMO_USE: begin
            cmd.op   = OP_SMO;
            state_in = ST_MAX_GO;
         end
         ST_MAX_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_LEVEL;
            state_in      = ST_MAX_WAIT;
         end
         ST_MAX_WAIT: if (status.div_done) state_in = ST_MAX_USE;
         ST_MAX_USE: begin
            cmd.op   = OP_MAX;
            state_in = ST_OLD_GO;
         end
         ST_OLD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FADE;
            state_in      = ST_OLD_WAIT;
         end
         ST_OLD_WAIT: if (status.div_done) state_in = ST_OLD_USE;
         ST_OLD_USE: begin
            cmd.op   = OP_OLD;
            state_in = ST_NEW_GO;
         end
         ST_NEW_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FADE;
            state_in      = ST_NEW_WAIT;
         end
         ST_NEW_WAIT: if (status.div_done) state_in = ST_NEW_USE;
         ST_NEW_USE: begin
            cmd.op   = OP_NEW;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/nmx_dp.sv =====
// Datapath: effect state, digit stores, LFSR, brightness filter, on-time math, result register.
// Depends on nmx_pkg and nmx_div.
`timescale 1ns / 1ps
`default_nettype none
module nmx_dp #(
   parameter int SLOT_MS    = nmx_pkg::SLOT_MS_DEF,
   parameter int FADE_STEPS = nmx_pkg::FADE_STEPS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire nmx_pkg::dp_cmd_type                cmd,
   output nmx_pkg::dp_status_type                  status,
   input  wire nmx_pkg::cfg_type                   cfg,
   input  wire logic                               req_data_valid,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]        req_digit_a,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]        req_digit_b,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]        req_digit_c,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]        req_digit_d,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]        req_digit_e,
   input  wire logic [nmx_pkg::DIGIT_W-1:0]        req_digit_f,
   input  wire logic                               req_power_off_request,
   input  wire logic                               req_hourly_trigger,
   input  wire logic                               req_demo_trigger,
   input  wire logic [nmx_pkg::LIGHT_W-1:0]        req_ambient_light,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [nmx_pkg::SLOT_W-1:0]              rsp_slot_digit,
   output logic [nmx_pkg::CATH_W-1:0]              rsp_old_cathodes,
   output logic [nmx_pkg::ON_W-1:0]                rsp_old_on_us,
   output logic [nmx_pkg::CATH_W-1:0]              rsp_new_cathodes,
   output logic [nmx_pkg::ON_W-1:0]                rsp_new_on_us,
   output logic                                    rsp_high_voltage_on,
   output logic [3:0]                              rsp_mode_now
);
   import nmx_pkg::*;

   localparam int FADE_W = $clog2(FADE_STEPS + 1);
   localparam int K_W    = FADE_W + 1;
   localparam logic [FADE_W-1:0]    F_FADE = FADE_W'(FADE_STEPS);
   localparam logic [K_W-1:0]       F_K    = K_W'(FADE_STEPS);
   localparam logic [ELAPSED_W:0]   SLOT_E = (ELAPSED_W + 1)'(SLOT_MS);

   // latched request
   logic                 dv_ff, dv_in, poff_ff, poff_in, hr_ff, hr_in, dm_ff, dm_in;
   logic [LIGHT_W-1:0]   amb_ff, amb_in;
   logic [DIGIT_W-1:0]   dig_ff [TUBES];
   logic [DIGIT_W-1:0]   dig_in [TUBES];

   // architectural state
   mode_type             mode_ff, mode_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [DIGIT_W-1:0]   shown_ff [TUBES];
   logic [DIGIT_W-1:0]   shown_in [TUBES];
   logic [DIGIT_W-1:0]   target_ff [TUBES];
   logic [DIGIT_W-1:0]   target_in [TUBES];
   logic [DIGIT_W-1:0]   locked_ff [TUBES];
   logic [DIGIT_W-1:0]   locked_in [TUBES];
   logic [DIGIT_W-1:0]   shuf_ff [TUBES];
   logic [DIGIT_W-1:0]   shuf_in [TUBES];
   logic [FADE_W-1:0]    fade_ff, fade_in;
   logic [BRIGHT_W-1:0]  sb_ff, sb_in;
   logic [15:0]          lfsr_ff, lfsr_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;

   // per-request work registers
   logic [DIGIT_W-1:0]   val_ff, val_in;
   logic                 blank_ff, blank_in, up_ff, up_in, mnz_ff, mnz_in;
   logic [ON_W-1:0]      maxon_ff, maxon_in, old_on_ff, old_on_in, new_on_ff, new_on_in;
   logic [K_W-1:0]       newk_ff, newk_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;

   // result register
   logic                 ov_ff, ov_in;
   logic [SLOT_W-1:0]    o_slot_ff, o_slot_in;
   logic [CATH_W-1:0]    o_oc_ff, o_oc_in, o_nc_ff, o_nc_in;
   logic [ON_W-1:0]      o_oon_ff, o_oon_in, o_non_ff, o_non_in;
   logic                 o_hv_ff, o_hv_in;
   logic [3:0]           o_mode_ff, o_mode_in;

   // divider
   logic [DIV_DEN_W-1:0] den;
   logic [DIV_NUM_W-1:0] quo;
   logic                 div_done;

   // helpers
   logic [1:0]           eff_mode;
   logic                 differ, full, up_w, expire;
   logic [SLOT_W-1:0]    pos;
   logic [ELAPSED_W-1:0] pos_e;
   logic [15:0]          lfsr_nxt;
   logic [LIGHT_W-1:0]   span, amb_off;
   logic [BRIGHT_W-1:0]  tgt, m, step, sb_new;
   logic [K_W-1:0]       fade2, oldk, newk;
   logic [ON_W-1:0]      maxon_w;
   logic [ELAPSED_W:0]   el_sum;

   always_comb begin
      eff_mode = (cfg.display_mode == DISP_SPARE) ? DISP_SWITCH : cfg.display_mode;
      span     = (cfg.light_max <= cfg.light_min) ? LIGHT_W'(1)
                                                  : cfg.light_max - cfg.light_min;
      unique case (cmd.div_sel)
         DIV_TGT:     den = DIV_DEN_W'(span);
         DIV_HUNDRED: den = DEN_HUNDRED;
         DIV_LEVEL:   den = DEN_LEVEL;
         DIV_FADE:    den = DIV_DEN_W'(FADE_STEPS);
         default:     den = DEN_HUNDRED;
      endcase
   end

   nmx_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den),
      .done  (div_done),
      .quo   (quo)
   );

   assign status.div_done = div_done;
   assign status.out_busy = ov_ff && rsp_stall;

   always_comb begin
      dv_in = dv_ff; poff_in = poff_ff; hr_in = hr_ff; dm_in = dm_ff; amb_in = amb_ff;
      dig_in = dig_ff;
      mode_in = mode_ff; elapsed_in = elapsed_ff;
      shown_in = shown_ff; target_in = target_ff; locked_in = locked_ff; shuf_in = shuf_ff;
      fade_in = fade_ff; sb_in = sb_ff; lfsr_in = lfsr_ff; slot_in = slot_ff;
      val_in = val_ff; blank_in = blank_ff; up_in = up_ff; mnz_in = mnz_ff;
      maxon_in = maxon_ff; old_on_in = old_on_ff; new_on_in = new_on_ff;
      newk_in = newk_ff; num_in = num_ff;
      ov_in = ov_ff && rsp_stall;
      o_slot_in = o_slot_ff; o_oc_in = o_oc_ff; o_nc_in = o_nc_ff;
      o_oon_in = o_oon_ff; o_non_in = o_non_ff; o_hv_in = o_hv_ff; o_mode_in = o_mode_ff;

      differ = 1'b0;
      for (int i = 0; i < TUBES; i++) if (dig_ff[i] != target_ff[i]) differ = 1'b1;
      lfsr_nxt = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_MASK : 16'h0000);
      pos      = SLOT_W'(TUBES - 1) - slot_ff;
      pos_e    = ELAPSED_W'(pos);
      amb_off  = amb_ff - cfg.light_min;
      if (amb_ff < cfg.light_min)      tgt = BRIGHT_LO_FX;
      else if (amb_ff > cfg.light_max) tgt = BRIGHT_HI_FX;
      else                             tgt = BRIGHT_LO_FX + quo[BRIGHT_W-1:0];
      up_w = tgt >= sb_ff;
      m    = up_w ? tgt - sb_ff : sb_ff - tgt;
      step = quo[BRIGHT_W-1:0];
      if (step == '0 && (!up_ff || mnz_ff)) step = BRIGHT_W'(1);
      sb_new = up_ff ? sb_ff + step : sb_ff - step;
      if (!cfg.brightness_auto) sb_new = {cfg.brightness_level, 8'h00};
      maxon_w = ON_BASE + quo[ON_W-1:0];
      full  = mode_ff != MODE_ON || fade_ff >= F_FADE || shown_ff[slot_ff] == target_ff[slot_ff];
      fade2 = {fade_ff, 1'b0};
      if (full) begin
         oldk = '0;
         newk = F_K;
      end else if (eff_mode == DISP_FADE) begin
         oldk = (fade2 < F_K) ? F_K - fade2 : '0;
         newk = (fade2 < F_K) ? '0 : fade2 - F_K;
      end else begin
         oldk = F_K - K_W'(fade_ff);
         newk = K_W'(fade_ff);
      end
      expire = 1'b0;
      el_sum = {1'b0, elapsed_ff} + SLOT_E;

      case (cmd.op)
         OP_LOAD: begin
            dv_in = req_data_valid; poff_in = req_power_off_request;
            hr_in = req_hourly_trigger; dm_in = req_demo_trigger; amb_in = req_ambient_light;
            dig_in[0] = req_digit_a; dig_in[1] = req_digit_b; dig_in[2] = req_digit_c;
            dig_in[3] = req_digit_d; dig_in[4] = req_digit_e; dig_in[5] = req_digit_f;
         end
         OP_REQ: begin
            if (dv_ff) begin
               if (mode_ff == MODE_ON && poff_ff) begin
                  mode_in = MODE_OFF_SHUF; elapsed_in = '0;
               end else if (mode_ff == MODE_OFF && !poff_ff) begin
                  mode_in = MODE_ON_SEQ; elapsed_in = '0;
               end else if (mode_ff == MODE_ON && hr_ff) begin
                  mode_in = MODE_HR_SHUF; elapsed_in = '0;
                  locked_in[0] = dig_ff[0]; locked_in[1] = dig_ff[1];
                  locked_in[2] = 4'd0; locked_in[3] = 4'd0;
                  locked_in[4] = 4'd0; locked_in[5] = 4'd6;
               end else if (mode_ff == MODE_ON && dm_ff) begin
                  mode_in = MODE_DM_SHUF; elapsed_in = '0;
                  locked_in = dig_ff;
               end
               if (differ) begin
                  shown_in  = target_ff;
                  target_in = dig_ff;
                  fade_in   = '0;
               end
            end
         end
         OP_LFSR: begin
            lfsr_in           = lfsr_nxt;
            shuf_in[cmd.tube] = mod10(lfsr_nxt);
         end
         OP_TIMER: begin
            case (mode_ff)
               MODE_OFF_SHUF: if (elapsed_ff >= T_SHUF) begin
                  mode_in = MODE_OFF_SEQ; elapsed_in = '0;
               end
               MODE_OFF_SEQ: if (elapsed_ff >= T_SEQ) begin
                  mode_in = MODE_OFF; elapsed_in = '0;
               end
               MODE_ON_SEQ: if (elapsed_ff >= T_SEQ) begin
                  mode_in = MODE_ON_SHUF; elapsed_in = '0;
               end
               MODE_ON_SHUF: if (elapsed_ff >= T_SHUF) begin
                  mode_in = MODE_ON_RES; elapsed_in = '0;
               end
               MODE_ON_RES:  expire = elapsed_ff >= T_SEQ;
               MODE_HR_SHUF: if (elapsed_ff >= T_HOURLY) begin
                  mode_in = MODE_HR_RES; elapsed_in = '0;
               end
               MODE_DM_SHUF: if (elapsed_ff >= T_DEMO) begin
                  mode_in = MODE_DM_RES; elapsed_in = '0;
               end
               MODE_HR_RES, MODE_DM_RES: expire = elapsed_ff >= T_LOCK_RES;
               default: expire = 1'b0;
            endcase
            if (expire) begin
               mode_in = MODE_ON; elapsed_in = '0;
               fade_in = F_FADE;
               shown_in = target_ff;
            end
         end
         OP_FADE: begin
            val_in   = shuf_ff[slot_ff];
            blank_in = 1'b0;
            case (mode_ff)
               MODE_ON:      val_in = target_ff[slot_ff];
               MODE_OFF_SEQ: blank_in = (pos_e + 1'b1) * STEP_SEQ <= elapsed_ff;
               MODE_ON_SEQ:  blank_in = elapsed_ff < pos_e * STEP_SEQ;
               MODE_ON_RES:  if (pos_e * STEP_SEQ <= elapsed_ff) val_in = target_ff[slot_ff];
               MODE_HR_RES, MODE_DM_RES:
                  if (pos_e * STEP_LOCK <= elapsed_ff) val_in = locked_ff[slot_ff];
               MODE_OFF:     blank_in = 1'b1;
               default:      blank_in = 1'b0;
            endcase
            if (fade_ff < F_FADE) fade_in = (eff_mode == DISP_SWITCH) ? F_FADE : fade_ff + 1'b1;
            num_in = DIV_NUM_W'(amb_off) * DIV_NUM_W'(TGT_SCALE);
         end
         OP_TGT: begin
            up_in  = up_w;
            mnz_in = m != '0;
            num_in = DIV_NUM_W'(m) + DIV_NUM_W'(ROUND_HALF);
         end
         OP_SMO: begin
            sb_in  = sb_new;
            num_in = DIV_NUM_W'(sb_new[15:8]) * DIV_NUM_W'(LEVEL_SCALE);
         end
         OP_MAX: begin
            maxon_in = maxon_w;
            newk_in  = newk;
            num_in   = DIV_NUM_W'(maxon_w) * DIV_NUM_W'(oldk);
         end
         OP_OLD: begin
            old_on_in = quo[ON_W-1:0];
            num_in    = DIV_NUM_W'(maxon_ff) * DIV_NUM_W'(newk_ff);
         end
         OP_NEW: new_on_in = quo[ON_W-1:0];
         OP_EMIT: begin
            ov_in     = 1'b1;
            o_slot_in = slot_ff;
            if (old_on_ff != '0 && mode_ff == MODE_ON) begin
               o_oc_in  = cath(shown_ff[slot_ff]);
               o_oon_in = old_on_ff;
            end else begin
               o_oc_in  = NO_CATH;
               o_oon_in = '0;
            end
            if (new_on_ff != '0 && !blank_ff) begin
               o_nc_in  = cath(val_ff);
               o_non_in = new_on_ff;
            end else begin
               o_nc_in  = NO_CATH;
               o_non_in = '0;
            end
            o_hv_in    = mode_ff != MODE_OFF;
            o_mode_in  = mode_ff;
            slot_in    = (slot_ff == SLOT_W'(TUBES - 1)) ? '0 : slot_ff + 1'b1;
            elapsed_in = (el_sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : el_sum[ELAPSED_W-1:0];
         end
         default: ov_in = ov_ff && rsp_stall;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         elapsed_ff <= '0;
         fade_ff    <= F_FADE;
         sb_ff      <= BRIGHT_HI_FX;
         lfsr_ff    <= LFSR_SEED;
         slot_ff    <= '0;
         ov_ff      <= 1'b0;
         for (int i = 0; i < TUBES; i++) begin
            shown_ff[i]  <= '0;
            target_ff[i] <= '0;
            locked_ff[i] <= '0;
            shuf_ff[i]   <= '0;
         end
      end else begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         fade_ff    <= fade_in;
         sb_ff      <= sb_in;
         lfsr_ff    <= lfsr_in;
         slot_ff    <= slot_in;
         ov_ff      <= ov_in;
         shown_ff   <= shown_in;
         target_ff  <= target_in;
         locked_ff  <= locked_in;
         shuf_ff    <= shuf_in;
      end
      dv_ff <= dv_in; poff_ff <= poff_in; hr_ff <= hr_in; dm_ff <= dm_in; amb_ff <= amb_in;
      dig_ff <= dig_in;
      val_ff <= val_in; blank_ff <= blank_in; up_ff <= up_in; mnz_ff <= mnz_in;
      maxon_ff <= maxon_in; old_on_ff <= old_on_in; new_on_ff <= new_on_in;
      newk_ff <= newk_in; num_ff <= num_in;
      o_slot_ff <= o_slot_in; o_oc_ff <= o_oc_in; o_nc_ff <= o_nc_in;
      o_oon_ff <= o_oon_in; o_non_ff <= o_non_in; o_hv_ff <= o_hv_in; o_mode_ff <= o_mode_in;
   end

   assign rsp_valid           = ov_ff;
   assign rsp_slot_digit      = o_slot_ff;
   assign rsp_old_cathodes    = o_oc_ff;
   assign rsp_old_on_us       = o_oon_ff;
   assign rsp_new_cathodes    = o_nc_ff;
   assign rsp_new_on_us       = o_non_ff;
   assign rsp_high_voltage_on = o_hv_ff;
   assign rsp_mode_now        = o_mode_ff;
endmodule
`default_nettype wire

// ===== rtl/nmx_checker.sv =====
// Port-level checks of the driver, bound onto the top level.
// Depends on nmx_pkg and nixie_multiplex_effect_driver_unit.
`timescale 1ns / 1ps
`default_nettype none
module nmx_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [nmx_pkg::SLOT_W-1:0]     rsp_slot_digit,
   input wire logic [nmx_pkg::CATH_W-1:0]     rsp_new_cathodes,
   input wire logic [nmx_pkg::ON_W-1:0]       rsp_old_on_us,
   input wire logic [nmx_pkg::ON_W-1:0]       rsp_new_on_us,
   input wire logic                           rsp_high_voltage_on,
   input wire logic [3:0]                     rsp_mode_now
);
   import nmx_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slot_digit <= SLOT_W'(TUBES - 1))
      else $error("slot out of range");

   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_now == MODE_OFF |->
         !rsp_high_voltage_on && rsp_new_on_us == '0 && rsp_old_on_us == '0)
      else $error("tube lit while off");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_cathodes))
      else $error("stalled response changed");
endmodule

bind nixie_multiplex_effect_driver_unit nmx_checker u_nmx_checker (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for the nixie multiplex/effect driver: random slot requests,
// bursty idling on both channels and a cycle-free predictor of the slot outputs.
// Depends on nmx_pkg and nixie_multiplex_effect_driver_unit.
`timescale 1ns / 1ps
module tb;
   import nmx_pkg::*;

   localparam int STEP_MS = 3;
   localparam int FADE_N  = 100;

   typedef struct {
      bit              dv;
      logic [5:0][3:0] digs;
      bit              poff;
      bit              hourly;
      bit              demo;
      logic [11:0]     light;
   } slot_req_t;

   typedef struct {
      logic [2:0]  slot;
      logic [15:0] oldc;
      logic [11:0] oldon;
      logic [15:0] newc;
      logic [11:0] newon;
      logic        hv;
      logic [3:0]  mode;
   } slot_out_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_data_valid = 1'b0;
   logic [3:0]  req_digit_a = '0, req_digit_b = '0, req_digit_c = '0;
   logic [3:0]  req_digit_d = '0, req_digit_e = '0, req_digit_f = '0;
   logic        req_power_off_request = 1'b0, req_hourly_trigger = 1'b0;
   logic        req_demo_trigger = 1'b0;
   logic [11:0] req_ambient_light = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_slot_digit;
   logic [15:0] rsp_old_cathodes, rsp_new_cathodes;
   logic [11:0] rsp_old_on_us, rsp_new_on_us;
   logic        rsp_high_voltage_on;
   logic [3:0]  rsp_mode_now;

   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   nixie_multiplex_effect_driver_unit i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: configuration copy plus the block's architectural state
   // ---------------------------------------------------------------------------
   logic [1:0]  cfg_disp;
   logic        cfg_auto;
   logic [7:0]  cfg_level;
   logic [11:0] cfg_lmin, cfg_lmax;

   mode_type        fx_mode;
   logic [12:0]     fx_ms;
   logic [5:0][3:0] shown_d, target_d, locked_d, shuf_d;
   int unsigned     fade_cnt, bright_fx, lfsr_q;
   logic [2:0]      tube_q;

   slot_req_t pending_reqs[$];
   slot_out_t expected_slots[$];
   int        fail_count = 0;
   bit        final_phase = 1'b0;

   function automatic logic [15:0] cathode_mask(input logic [3:0] v);
      logic [15:0] m;
      m = 16'hFFFF;
      if (v == 4'd0) m[9] = 1'b0;
      else if (v <= 4'd9) m[v - 1] = 1'b0;
      return m;
   endfunction

   function automatic void enter_mode(input mode_type m);
      fx_mode = m;
      fx_ms   = '0;
   endfunction

   // Advances the predicted state by one slot and returns what the slot drives.
   function automatic slot_out_t predict_slot(input slot_req_t r);
      slot_out_t   o;
      int unsigned s, pos, n, lvl, maxon, old_on, new_on, dm, mx, tgt, diff, stepv, e;
      logic [3:0]  val;
      bit          blank, b;
      blank = 0;
      old_on = 0;
      new_on = 0;
      dm = (cfg_disp == DISP_SPARE) ? DISP_SWITCH : cfg_disp;

      if (r.dv) begin
         if (fx_mode == MODE_ON && r.poff) enter_mode(MODE_OFF_SHUF);
         else if (fx_mode == MODE_OFF && !r.poff) enter_mode(MODE_ON_SEQ);
         else if (fx_mode == MODE_ON && r.hourly) begin
            enter_mode(MODE_HR_SHUF);
            locked_d = {4'd6, 4'd0, 4'd0, 4'd0, r.digs[1], r.digs[0]};
         end else if (fx_mode == MODE_ON && r.demo) begin
            enter_mode(MODE_DM_SHUF);
            locked_d = r.digs;
         end
         if (r.digs != target_d) begin
            shown_d  = target_d;
            target_d = r.digs;
            fade_cnt = 0;
         end
      end

      for (int i = 0; i < 6; i++) begin
         b = lfsr_q[0];
         lfsr_q = lfsr_q >> 1;
         if (b) lfsr_q ^= LFSR_MASK;
         shuf_d[i] = 4'(lfsr_q % 10);
      end

      // effect timers
      case (fx_mode)
         MODE_OFF_SHUF: if (fx_ms >= T_SHUF) enter_mode(MODE_OFF_SEQ);
         MODE_OFF_SEQ:  if (fx_ms >= T_SEQ) enter_mode(MODE_OFF);
         MODE_ON_SEQ:   if (fx_ms >= T_SEQ) enter_mode(MODE_ON_SHUF);
         MODE_ON_SHUF:  if (fx_ms >= T_SHUF) enter_mode(MODE_ON_RES);
         MODE_HR_SHUF:  if (fx_ms >= T_HOURLY) enter_mode(MODE_HR_RES);
         MODE_DM_SHUF:  if (fx_ms >= T_DEMO) enter_mode(MODE_DM_RES);
         MODE_ON_RES, MODE_HR_RES, MODE_DM_RES: begin
            if ((fx_mode == MODE_ON_RES && fx_ms >= T_SEQ) ||
                (fx_mode != MODE_ON_RES && fx_ms >= T_LOCK_RES)) begin
               enter_mode(MODE_ON);
               fade_cnt = FADE_N;
               shown_d  = target_d;
            end
         end
         default: ;
      endcase

      s   = tube_q;
      pos = 5 - s;
      val = shuf_d[s];
      case (fx_mode)
         MODE_ON:      val = target_d[s];
         MODE_OFF_SEQ: begin n = fx_ms / 100; if (pos < n) blank = 1; end
         MODE_ON_SEQ:  begin n = fx_ms / 100; if (pos > n) blank = 1; end
         MODE_ON_RES:  begin n = fx_ms / 100; if (pos <= n) val = target_d[s]; end
         MODE_HR_RES, MODE_DM_RES: begin
            n = fx_ms / 500;
            if (pos <= n) val = locked_d[s];
         end
         MODE_OFF:     blank = 1;
         default: ;
      endcase

      if (fade_cnt < FADE_N) fade_cnt = (dm == DISP_SWITCH) ? FADE_N : fade_cnt + 1;

      // brightness: manual level, or ambient map through the low-pass
      if (!cfg_auto) begin
         bright_fx = cfg_level << 8;
         lvl = cfg_level;
      end else begin
         mx = cfg_lmax;
         if (mx <= cfg_lmin) mx = cfg_lmin + 1;
         if (r.light < cfg_lmin) tgt = 20 << 8;
         else if (r.light > cfg_lmax) tgt = 255 << 8;
         else tgt = (20 << 8) + ((r.light - cfg_lmin) * 60160) / (mx - cfg_lmin);
         if (tgt >= bright_fx) begin
            diff  = tgt - bright_fx;
            stepv = (diff + 50) / 100;
            if (stepv == 0 && diff > 0) stepv = 1;
            bright_fx += stepv;
         end else begin
            diff  = bright_fx - tgt;
            stepv = (diff + 50) / 100;
            if (stepv == 0) stepv = 1;
            bright_fx -= stepv;
         end
         bright_fx &= 32'hFFFF;
         lvl = bright_fx >> 8;
      end
      maxon = 100 + (lvl * 2700) / 255;

      if (fx_mode != MODE_ON || fade_cnt >= FADE_N || shown_d[s] == target_d[s])
         new_on = maxon;
      else if (dm == DISP_FADE) begin
         if (fade_cnt * 2 < FADE_N) old_on = maxon * (FADE_N - fade_cnt * 2) / FADE_N;
         else new_on = maxon * (fade_cnt * 2 - FADE_N) / FADE_N;
      end else begin
         old_on = maxon * (FADE_N - fade_cnt) / FADE_N;
         new_on = maxon * fade_cnt / FADE_N;
      end

      o.slot = 3'(s);
      if (old_on > 0 && fx_mode == MODE_ON) begin
         o.oldc  = cathode_mask(shown_d[s]);
         o.oldon = 12'(old_on);
      end else begin
         o.oldc  = NO_CATH;
         o.oldon = '0;
      end
      if (new_on > 0 && !blank) begin
         o.newc  = cathode_mask(val);
         o.newon = 12'(new_on);
      end else begin
         o.newc  = NO_CATH;
         o.newon = '0;
      end
      o.hv   = (fx_mode != MODE_OFF);
      o.mode = fx_mode;

      tube_q = (s == 5) ? 3'd0 : 3'(s + 1);
      e = fx_ms + STEP_MS;
      fx_ms = (e > 8191) ? 13'd8191 : 13'(e);
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: pops queued requests, predicts each one as it is accepted
   // ---------------------------------------------------------------------------
   int  req_gap = 0;
   wire calm = final_phase && pending_reqs.size() < 300;

   always @(posedge clock) begin
      slot_req_t r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            r.dv     = req_data_valid;
            r.digs   = {req_digit_f, req_digit_e, req_digit_d,
                        req_digit_c, req_digit_b, req_digit_a};
            r.poff   = req_power_off_request;
            r.hourly = req_hourly_trigger;
            r.demo   = req_demo_trigger;
            r.light  = req_ambient_light;
            expected_slots.push_back(predict_slot(r));
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0 && !calm) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               r = pending_reqs.pop_front();
               req_valid             <= 1'b1;
               req_data_valid        <= r.dv;
               req_digit_a           <= r.digs[0];
               req_digit_b           <= r.digs[1];
               req_digit_c           <= r.digs[2];
               req_digit_d           <= r.digs[3];
               req_digit_e           <= r.digs[4];
               req_digit_f           <= r.digs[5];
               req_power_off_request <= r.poff;
               req_hourly_trigger    <= r.hourly;
               req_demo_trigger      <= r.demo;
               req_ambient_light     <= r.light;
               req_gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor with bursty backpressure
   // ---------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      slot_out_t x;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_slots.size() == 0) begin
               $error("slot result with no request outstanding");
               fail_count++;
            end else begin
               x = expected_slots.pop_front();
               if (rsp_slot_digit !== x.slot) begin
                  $error("slot_digit exp %0d got %0d", x.slot, rsp_slot_digit);
                  fail_count++;
               end
               if (rsp_old_cathodes !== x.oldc) begin
                  $error("old_cathodes exp %h got %h", x.oldc, rsp_old_cathodes);
                  fail_count++;
               end
               if (rsp_old_on_us !== x.oldon) begin
                  $error("old_on_us exp %0d got %0d", x.oldon, rsp_old_on_us);
                  fail_count++;
               end
               if (rsp_new_cathodes !== x.newc) begin
                  $error("new_cathodes exp %h got %h", x.newc, rsp_new_cathodes);
                  fail_count++;
               end
               if (rsp_new_on_us !== x.newon) begin
                  $error("new_on_us exp %0d got %0d", x.newon, rsp_new_on_us);
                  fail_count++;
               end
               if (rsp_high_voltage_on !== x.hv) begin
                  $error("high_voltage_on exp %0d got %0d", x.hv, rsp_high_voltage_on);
                  fail_count++;
               end
               if (rsp_mode_now !== x.mode) begin
                  $error("mode_now exp %0d got %0d", x.mode, rsp_mode_now);
                  fail_count++;
               end
            end
         end
         // stall bursts; none near the end of the run
         if (calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   logic [5:0][3:0] last_digs = '0;

   function automatic logic [11:0] pick_light();
      case ($urandom_range(0, 5))
         0: return 12'd0;
         1: return 12'hFFF;
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // Mostly plain ticks; now and then new digits and rare requests so that
   // long effects run to completion.
   function automatic slot_req_t random_req();
      slot_req_t r;
      r.dv = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 1) == 0) r.digs = last_digs;
      else for (int i = 0; i < 6; i++)
         r.digs[i] = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 9));
      if (r.dv) last_digs = r.digs;
      r.poff   = ($urandom_range(0, 29) == 0);
      r.hourly = ($urandom_range(0, 39) == 0);
      r.demo   = ($urandom_range(0, 59) == 0);
      r.light  = pick_light();
      return r;
   endfunction

   function automatic slot_req_t make_req(input bit dv, input logic [5:0][3:0] d,
                                          input bit poff, input bit hr, input bit dmo,
                                          input logic [11:0] lt);
      slot_req_t r;
      r.dv = dv; r.digs = d; r.poff = poff; r.hourly = hr; r.demo = dmo; r.light = lt;
      return r;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         CSR_DISPLAY_MODE: cfg_disp  = v[1:0];
         CSR_BRIGHT_AUTO:  cfg_auto  = v[0];
         CSR_BRIGHT_LEVEL: cfg_level = v[7:0];
         CSR_LIGHT_MIN:    cfg_lmin  = v[11:0];
         CSR_LIGHT_MAX:    cfg_lmax  = v[11:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_slots.size() > 0 || req_valid)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] dm, input bit au, input logic [7:0] lv,
                             input logic [11:0] lo, input logic [11:0] hi);
      csr_write(CSR_DISPLAY_MODE, dm);
      csr_write(CSR_BRIGHT_AUTO, au);
      csr_write(CSR_BRIGHT_LEVEL, lv);
      csr_write(CSR_LIGHT_MIN, lo);
      csr_write(CSR_LIGHT_MAX, hi);
   endtask

   initial begin
      int wait_cycles;
      cfg_disp = DISP_SWITCH; cfg_auto = 0; cfg_level = 8'd255;
      cfg_lmin = 12'd100; cfg_lmax = 12'd3000;
      fx_mode = MODE_OFF; fx_ms = '0; fade_cnt = FADE_N; bright_fx = 32'hFF00;
      lfsr_q = LFSR_SEED; tube_q = '0;
      shown_d = '0; target_d = '0; locked_d = '0; shuf_d = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_config(DISP_SWITCH, 1'b0, 8'd255, 12'd100, 12'd3000);

      // directed: requests while off are ignored, then power on and field extremes
      pending_reqs.push_back(make_req(1, '0, 1, 1, 1, 12'd0));
      pending_reqs.push_back(make_req(0, {6{4'hF}}, 1, 1, 1, 12'hFFF));
      pending_reqs.push_back(make_req(1, {4'd9, 4'd0, 4'd9, 4'd0, 4'd9, 4'd0}, 0, 0, 0, 12'd0));
      pending_reqs.push_back(make_req(1, {6{4'hF}}, 0, 0, 0, 12'hFFF));
      pending_reqs.push_back(make_req(1, {4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6}, 0, 0, 0, 12'd100));
      pending_reqs.push_back(make_req(1, {4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'h7}, 0, 0, 0, 12'd3000));
      // ride through the power-on sequence so the running-state requests land
      for (int i = 0; i < 760; i++) pending_reqs.push_back(make_req(0, '0, 0, 0, 0, pick_light()));
      pending_reqs.push_back(make_req(1, {4'd8, 4'd5, 4'd9, 4'd5, 4'd2, 4'd1}, 0, 1, 0, 12'd50));
      pending_reqs.push_back(make_req(1, {4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}, 0, 0, 1, 12'd50));
      drain();

      // random phases over several register settings, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_config(DISP_FADE, 1'b1, 8'd0, 12'd0, 12'd4095);
            1: set_config(DISP_XFADE, 1'b1, 8'd17, 12'd2000, 12'd1000);
            2: set_config(DISP_SPARE, 1'b0, 8'd128, 12'd4095, 12'd0);
            3: set_config(DISP_XFADE, 1'b0, 8'd0, 12'd100, 12'd3000);
            default: set_config(DISP_FADE, 1'b1, 8'd255, 12'd500, 12'd501);
         endcase
         if (ph == 4) final_phase = 1'b1;
         for (int i = 0; i < 1000; i++) pending_reqs.push_back(random_req());
         if (ph < 4) drain();
      end

      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      wait_cycles = 0;
      while (expected_slots.size() > 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_slots.size() > 0) begin
         $error("%0d slot results never arrived", expected_slots.size());
         fail_count++;
      end
      repeat (150) @(posedge clock);
      if (fail_count == 0) $display("nixie_multiplex_effect_driver_unit verification clean");
      else $display("nixie_multiplex_effect_driver_unit verification failed");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("nixie_multiplex_effect_driver_unit verification failed");
      $finish;
   end

endmodule
